[hw/rtl/masked_interrupt_controller_top_macros.svh]
// assertion helpers shared by the controller modules
// each one expects clk and rst_n in the scope where it is used
`ifndef MASKED_INTERRUPT_CONTROLLER_TOP_MACROS_SVH
`define MASKED_INTERRUPT_CONTROLLER_TOP_MACROS_SVH

`ifndef SYNTH

`define MIC_ASSERT_IMP(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("mic assertion failed");

`define MIC_ASSERT_NXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("mic assertion failed");

`define MIC_ASSERT_DLY2(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> ##2 (post)) \
        else $error("mic assertion failed");

`else

`define MIC_ASSERT_IMP(label, pre, post)

`define MIC_ASSERT_NXT(label, pre, post)

`define MIC_ASSERT_DLY2(label, pre, post)

`endif

`endif

[hw/rtl/mic_pkg.sv]
`timescale 1ns / 1ps

package mic_pkg;

    localparam int DATA_W   = 32;
    localparam int OFF_W    = 12;
    localparam int SRC_W    = 7;
    localparam int BANK_W   = 2;

    typedef enum logic [1:0] {
        FUNC_READ  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_LINES = 2'd2,
        FUNC_NOP   = 2'd3
    } func_t;

    localparam logic [OFF_W-1:0] OFF_SYSCONFIG = 12'h010;
    localparam logic [OFF_W-1:0] OFF_SIR_IRQ   = 12'h040;
    localparam logic [OFF_W-1:0] OFF_CONTROL   = 12'h048;
    localparam logic [OFF_W-1:0] OFF_BANK_BASE = 12'h080;

    // register offsets inside one bank window
    localparam logic [4:0] REG_RAW       = 5'h00;
    localparam logic [4:0] REG_MASK      = 5'h04;
    localparam logic [4:0] REG_MASK_CLR  = 5'h08;
    localparam logic [4:0] REG_MASK_SET  = 5'h0C;
    localparam logic [4:0] REG_FORCE_SET = 5'h10;
    localparam logic [4:0] REG_FORCE_CLR = 5'h14;
    localparam logic [4:0] REG_PENDING   = 5'h18;

    localparam logic [DATA_W-1:0] SIR_SPURIOUS = 32'hFFFF_FF80;

    typedef struct packed {
        func_t             func;
        logic [OFF_W-1:0]  offset;
        logic [DATA_W-1:0] wdata;
        logic [BANK_W-1:0] bank;
        logic [DATA_W-1:0] levels;
    } step_t;

    typedef struct packed {
        logic [DATA_W-1:0] rdata;
        logic              irq;
        logic [SRC_W-1:0]  source;
        logic              spurious;
    } result_t;

endpackage

[hw/rtl/mic_lowest_enc.sv]
`timescale 1ns / 1ps

module mic_lowest_enc #(
    parameter int W = 96
) (
    input  logic [W-1:0]              pend,
    output logic                      found,
    output logic [mic_pkg::SRC_W-1:0] idx
);

    logic [W-1:0] lowest;

    // isolate the lowest set bit, then encode the one-hot vector
    assign lowest = pend & (~pend + W'(1));
    assign found  = |pend;

    always_comb
    begin
        idx = '0;
        for (int i = 0; i < W; i++)
        begin
            if (lowest[i])
            begin
                idx = idx | mic_pkg::SRC_W'(i);
            end
        end
    end

endmodule

[hw/rtl/mic_core.sv]
`timescale 1ns / 1ps
`include "masked_interrupt_controller_top_macros.svh"

module mic_core #(
    parameter int NUM_SOURCES = 96,
    parameter int NUM_BANKS   = 3
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step_valid,
    input  mic_pkg::step_t   step,
    output mic_pkg::result_t res
);

    localparam int NBITS = NUM_BANKS * 32;

    logic [31:0] mask_reg  [NUM_BANKS];
    logic [31:0] force_reg [NUM_BANKS];
    logic [31:0] raw_reg   [NUM_BANKS];
    logic [31:0] mask_next  [NUM_BANKS];
    logic [31:0] force_next [NUM_BANKS];
    logic [31:0] raw_next   [NUM_BANKS];

    logic                      valid_reg, valid_next;
    logic [mic_pkg::SRC_W-1:0] latch_reg, latch_next;

    logic [mic_pkg::OFF_W-1:0] off;
    logic [mic_pkg::OFF_W-1:0] off_rel;
    logic [6:0]                bank_sel;
    logic [4:0]                reg_sel;
    logic                      in_bank;
    logic                      is_write, is_read, lines_wr;
    logic                      srst_hit, ack_hit, bank_wr;

    logic [NBITS-1:0]          src_ok;
    logic [NBITS-1:0]          pend_cur, pend_nxt;
    logic                      enc_found;
    logic [mic_pkg::SRC_W-1:0] enc_idx;
    logic [31:0]               rdata;

    // low two offset bits are ignored
    assign off      = {step.offset[mic_pkg::OFF_W-1:2], 2'b00};
    assign off_rel  = off - mic_pkg::OFF_BANK_BASE;
    assign bank_sel = off_rel[11:5];
    assign reg_sel  = off_rel[4:0];
    assign in_bank  = (off >= mic_pkg::OFF_BANK_BASE) && (32'(bank_sel) < NUM_BANKS);

    assign is_read  = step_valid && (step.func == mic_pkg::FUNC_READ);
    assign is_write = step_valid && (step.func == mic_pkg::FUNC_WRITE);
    assign lines_wr = step_valid && (step.func == mic_pkg::FUNC_LINES)
                      && (32'(step.bank) < NUM_BANKS);
    assign srst_hit = is_write && (off == mic_pkg::OFF_SYSCONFIG) && step.wdata[1];
    assign ack_hit  = is_write && (off == mic_pkg::OFF_CONTROL) && step.wdata[0];
    assign bank_wr  = is_write && in_bank;

    always_comb
    begin
        for (int i = 0; i < NBITS; i++)
        begin
            src_ok[i] = (i < NUM_SOURCES);
        end
    end

    always_comb
    begin
        for (int n = 0; n < NUM_BANKS; n++)
        begin
            mask_next[n]  = mask_reg[n];
            force_next[n] = force_reg[n];
            raw_next[n]   = raw_reg[n];
            if (srst_hit)
            begin
                mask_next[n]  = '1;
                force_next[n] = '0;
            end
            else if (bank_wr && (bank_sel == 7'(n)))
            begin
                unique case (reg_sel)
                    mic_pkg::REG_MASK:      mask_next[n]  = step.wdata;
                    mic_pkg::REG_MASK_CLR:  mask_next[n]  = mask_reg[n] & ~step.wdata;
                    mic_pkg::REG_MASK_SET:  mask_next[n]  = mask_reg[n] | step.wdata;
                    mic_pkg::REG_FORCE_SET: force_next[n] = force_reg[n] | step.wdata;
                    mic_pkg::REG_FORCE_CLR: force_next[n] = force_reg[n] & ~step.wdata;
                    default: ;
                endcase
            end
            if (lines_wr && (step.bank == mic_pkg::BANK_W'(n)))
            begin
                raw_next[n] = step.levels;
            end
            pend_cur[n*32 +: 32] = (raw_reg[n] | force_reg[n]) & ~mask_reg[n]
                                   & src_ok[n*32 +: 32];
            pend_nxt[n*32 +: 32] = (raw_next[n] | force_next[n]) & ~mask_next[n]
                                   & src_ok[n*32 +: 32];
        end
    end

    mic_lowest_enc #(
        .W (NBITS)
    ) u_enc (
        .pend  (pend_nxt),
        .found (enc_found),
        .idx   (enc_idx)
    );

    // reads see the state before the beat; it is already arbitrated
    always_comb
    begin
        rdata = '0;
        if (is_read)
        begin
            if (off == mic_pkg::OFF_SIR_IRQ)
            begin
                rdata = valid_reg ? {25'd0, latch_reg} : (mic_pkg::SIR_SPURIOUS | {25'd0, latch_reg});
            end
            else if (in_bank)
            begin
                for (int n = 0; n < NUM_BANKS; n++)
                begin
                    if (bank_sel == 7'(n))
                    begin
                        unique case (reg_sel)
                            mic_pkg::REG_RAW:       rdata = raw_reg[n];
                            mic_pkg::REG_MASK:      rdata = mask_reg[n];
                            mic_pkg::REG_FORCE_SET: rdata = force_reg[n];
                            mic_pkg::REG_PENDING:   rdata = pend_cur[n*32 +: 32];
                            default:                rdata = '0;
                        endcase
                    end
                end
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        latch_next = latch_reg;
        if (srst_hit)
        begin
            valid_next = 1'b0;
            latch_next = '0;
        end
        else if (ack_hit)
        begin
            valid_next = 1'b0;
        end
        if (!valid_next && enc_found)
        begin
            valid_next = 1'b1;
            latch_next = enc_idx;
        end
    end

    assign res.rdata    = rdata;
    assign res.irq      = valid_next;
    assign res.source   = latch_next;
    assign res.spurious = !valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < NUM_BANKS; n++)
            begin
                mask_reg[n]  <= '1;
                force_reg[n] <= '0;
                raw_reg[n]   <= '0;
            end
            valid_reg <= 1'b0;
            latch_reg <= '0;
        end
        else
        begin
            for (int n = 0; n < NUM_BANKS; n++)
            begin
                mask_reg[n]  <= mask_next[n];
                force_reg[n] <= force_next[n];
                raw_reg[n]   <= raw_next[n];
            end
            valid_reg <= valid_next;
            latch_reg <= latch_next;
        end
    end

    // a latched irq holds until acknowledge or soft reset
    `MIC_ASSERT_NXT(a_latch_holds, valid_reg && !srst_hit && !ack_hit, valid_reg && $stable(latch_reg))
    // nothing latched means nothing pending
    `MIC_ASSERT_IMP(a_idle_no_pend, !valid_reg, pend_cur == '0)
    `MIC_ASSERT_IMP(a_latch_in_range, valid_reg, 32'(latch_reg) < NUM_SOURCES)

endmodule

[hw/rtl/masked_interrupt_controller_top.sv]
`timescale 1ns / 1ps
// channel | ports                                                    | beat taken when
// input   | start busy func byte_offset write_data line_bank line_levels | start && !busy
// result  | done read_data irq_request active_source spurious       | done, one cycle
//
// one beat per cycle; a result is on the ports once its input beat has passed the input register
// and the result register
// input register -> decode, state update and priority encode -> result register
// busy is always low, and reset returns the banks and the irq latch to their reset values
// results cannot be stalled: each is shown for exactly one cycle with done high
`include "masked_interrupt_controller_top_macros.svh"

module masked_interrupt_controller_top #(
    parameter int NUM_SOURCES = 96,
    parameter int NUM_BANKS   = 3
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         func,
    input  logic [mic_pkg::OFF_W-1:0]          byte_offset,
    input  logic [mic_pkg::DATA_W-1:0]         write_data,
    input  logic [mic_pkg::BANK_W-1:0]         line_bank,
    input  logic [mic_pkg::DATA_W-1:0]         line_levels,
    output logic                               done,
    output logic [mic_pkg::DATA_W-1:0]         read_data,
    output logic                               irq_request,
    output logic [mic_pkg::SRC_W-1:0]          active_source,
    output logic                               spurious
);

    logic             accept;
    logic             in_valid_reg;
    mic_pkg::step_t   in_item_reg;
    mic_pkg::result_t core_res;
    logic             done_reg;
    mic_pkg::result_t res_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg <= accept;
            done_reg     <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg.func   <= mic_pkg::func_t'(func);
            in_item_reg.offset <= byte_offset;
            in_item_reg.wdata  <= write_data;
            in_item_reg.bank   <= line_bank;
            in_item_reg.levels <= line_levels;
        end
        if (in_valid_reg)
        begin
            res_reg <= core_res;
        end
    end

    mic_core #(
        .NUM_SOURCES (NUM_SOURCES),
        .NUM_BANKS   (NUM_BANKS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_valid (in_valid_reg),
        .step       (in_item_reg),
        .res        (core_res)
    );

    assign done          = done_reg;
    assign read_data     = res_reg.rdata;
    assign irq_request   = res_reg.irq;
    assign active_source = res_reg.source;
    assign spurious      = res_reg.spurious;

    `MIC_ASSERT_DLY2(a_beat_gives_result, accept, done)
    `MIC_ASSERT_DLY2(a_no_beat_no_result, !accept, !done)
    `MIC_ASSERT_IMP(a_irq_vs_spurious, done, irq_request != spurious)

endmodule

[sim/tb_masked_interrupt_controller_top.sv]
`timescale 1ns / 1ps

module tb_masked_interrupt_controller_top;

    import mic_pkg::*;

    localparam int NUM_SOURCES  = 96;
    localparam int NUM_BANKS    = 3;
    localparam int RANDOM_BEATS = 624;
    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 6;

    localparam logic [OFF_W-1:0] BANK_STRIDE = 12'h020;
    localparam logic [OFF_W-1:0] WORD_ALIGN  = 12'hFFC;
    localparam logic [OFF_W-1:0] OFF_TOP     = 12'hFFC;
    localparam logic [4:0] BANK_REGS [7] = '{REG_RAW, REG_MASK, REG_MASK_CLR, REG_MASK_SET,
                                             REG_FORCE_SET, REG_FORCE_CLR, REG_PENDING};

    function automatic logic [OFF_W-1:0] reg_at(int bank, logic [4:0] r);
        return OFF_BANK_BASE + BANK_STRIDE * OFF_W'(bank) + OFF_W'(r);
    endfunction

    typedef struct packed {
        step_t   beat;
        bit      typed;
        result_t want;
    } stim_row_t;

    localparam result_t FROM_MODEL = '0;

    localparam int NUM_ROWS = 26;
    localparam stim_row_t DIRECTED [NUM_ROWS] = '{
        // out of reset: nothing latched, everything masked
        '{'{FUNC_READ, OFF_SIR_IRQ, 32'h0, 2'd0, 32'h0}, 1'b1,
          '{SIR_SPURIOUS, 1'b0, 7'd0, 1'b1}},
        '{'{FUNC_READ, reg_at(0, REG_MASK), 32'h0, 2'd0, 32'h0}, 1'b1,
          '{32'hFFFF_FFFF, 1'b0, 7'd0, 1'b1}},
        '{'{FUNC_READ, reg_at(2, REG_FORCE_SET), 32'h0, 2'd0, 32'h0}, 1'b1,
          '{32'h0, 1'b0, 7'd0, 1'b1}},
        '{'{FUNC_LINES, 12'h0, 32'h0, 2'd0, 32'hFFFF_FFFF}, 1'b1,
          '{32'h0, 1'b0, 7'd0, 1'b1}},
        // lines for a bank that does not exist
        '{'{FUNC_LINES, 12'h0, 32'h0, 2'd3, 32'hFFFF_FFFF}, 1'b1,
          '{32'h0, 1'b0, 7'd0, 1'b1}},
        '{'{FUNC_WRITE, reg_at(0, REG_MASK_CLR), 32'h0000_0020, 2'd0, 32'h0}, 1'b1,
          '{32'h0, 1'b1, 7'd5, 1'b0}},
        '{'{FUNC_READ, OFF_SIR_IRQ, 32'h0, 2'd0, 32'h0}, 1'b1,
          '{32'h5, 1'b1, 7'd5, 1'b0}},
        '{'{FUNC_READ, reg_at(0, REG_PENDING), 32'h0, 2'd0, 32'h0}, 1'b1,
          '{32'h0000_0020, 1'b1, 7'd5, 1'b0}},
        '{'{FUNC_WRITE, reg_at(0, REG_MASK_SET), 32'h0000_0020, 2'd0, 32'h0}, 1'b0, FROM_MODEL},
        // ack with nothing else pending, latch keeps the old number
        '{'{FUNC_WRITE, OFF_CONTROL, 32'h1, 2'd0, 32'h0}, 1'b0, FROM_MODEL},
        '{'{FUNC_WRITE, reg_at(2, REG_FORCE_SET), 32'h8000_0000, 2'd0, 32'h0}, 1'b0, FROM_MODEL},
        '{'{FUNC_WRITE, reg_at(2, REG_MASK), 32'h0, 2'd0, 32'h0}, 1'b0, FROM_MODEL},
        '{'{FUNC_READ, reg_at(2, REG_PENDING), 32'h0, 2'd0, 32'h0}, 1'b0, FROM_MODEL},
        '{'{FUNC_READ, OFF_SIR_IRQ | 12'h3, 32'h0, 2'd0, 32'h0}, 1'b0, FROM_MODEL},
        '{'{FUNC_READ, reg_at(0, REG_MASK_CLR), 32'h0, 2'd0, 32'h0}, 1'b0, FROM_MODEL},
        '{'{FUNC_READ, OFF_TOP, 32'h0, 2'd0, 32'h0}, 1'b0, FROM_MODEL},
        '{'{FUNC_WRITE, OFF_TOP, 32'hFFFF_FFFF, 2'd0, 32'h0}, 1'b0, FROM_MODEL},
        '{'{FUNC_NOP, OFF_SIR_IRQ, 32'hFFFF_FFFF, 2'd3, 32'hFFFF_FFFF}, 1'b0, FROM_MODEL},
        '{'{FUNC_WRITE, reg_at(2, REG_FORCE_CLR), 32'hFFFF_FFFF, 2'd0, 32'h0}, 1'b0, FROM_MODEL},
        '{'{FUNC_WRITE, OFF_CONTROL, 32'h0, 2'd0, 32'h0}, 1'b0, FROM_MODEL},
        '{'{FUNC_WRITE, OFF_CONTROL, 32'hFFFF_FFFF, 2'd0, 32'h0}, 1'b0, FROM_MODEL},
        '{'{FUNC_LINES, 12'h0, 32'h0, 2'd1, 32'h0000_0001}, 1'b0, FROM_MODEL},
        '{'{FUNC_WRITE, reg_at(1, REG_MASK), 32'h0, 2'd0, 32'h0}, 1'b0, FROM_MODEL},
        '{'{FUNC_WRITE, OFF_SYSCONFIG, 32'h1, 2'd0, 32'h0}, 1'b0, FROM_MODEL},
        '{'{FUNC_WRITE, OFF_SYSCONFIG, 32'h2, 2'd0, 32'h0}, 1'b0, FROM_MODEL},
        // soft reset leaves the raw lines alone
        '{'{FUNC_READ, reg_at(0, REG_RAW), 32'h0, 2'd0, 32'h0}, 1'b1,
          '{32'hFFFF_FFFF, 1'b0, 7'd0, 1'b1}}
    };

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [1:0]          func;
    logic [OFF_W-1:0]    byte_offset;
    logic [DATA_W-1:0]   write_data;
    logic [BANK_W-1:0]   line_bank;
    logic [DATA_W-1:0]   line_levels;
    logic                done;
    logic [DATA_W-1:0]   read_data;
    logic                irq_request;
    logic [SRC_W-1:0]    active_source;
    logic                spurious;

    // predicted controller state
    logic [DATA_W-1:0]   mask_st  [NUM_BANKS];
    logic [DATA_W-1:0]   force_st [NUM_BANKS];
    logic [DATA_W-1:0]   line_st  [NUM_BANKS];
    logic [SRC_W-1:0]    irq_num;
    bit                  irq_held;

    result_t             resp_q [$];
    int                  fail_count = 0;
    int                  cycle_count = 0;

    masked_interrupt_controller_top #(
        .NUM_SOURCES (NUM_SOURCES),
        .NUM_BANKS   (NUM_BANKS)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .func          (func),
        .byte_offset   (byte_offset),
        .write_data    (write_data),
        .line_bank     (line_bank),
        .line_levels   (line_levels),
        .done          (done),
        .read_data     (read_data),
        .irq_request   (irq_request),
        .active_source (active_source),
        .spurious      (spurious)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void clear_regs();
        for (int b = 0; b < NUM_BANKS; b++)
        begin
            mask_st[b]  = '1;
            force_st[b] = '0;
        end
        irq_num  = '0;
        irq_held = 1'b0;
    endfunction

    function automatic logic [DATA_W-1:0] bank_pending(int b);
        int                lo;
        logic [DATA_W-1:0] live;
        lo = b * 32;
        if (NUM_SOURCES >= lo + 32)
            live = '1;
        else if (NUM_SOURCES <= lo)
            live = '0;
        else
            live = (32'd1 << (NUM_SOURCES - lo)) - 32'd1;
        return (line_st[b] | force_st[b]) & ~mask_st[b] & live;
    endfunction

    // lowest pending source wins, only when nothing is latched
    function automatic void pick_irq();
        logic [DATA_W-1:0] p;
        if (irq_held)
            return;
        for (int b = 0; b < NUM_BANKS; b++)
        begin
            p = bank_pending(b);
            for (int k = 0; k < 32; k++)
            begin
                if (p[k])
                begin
                    irq_num  = SRC_W'(b * 32 + k);
                    irq_held = 1'b1;
                    return;
                end
            end
        end
    endfunction

    function automatic result_t predict_beat(step_t s);
        logic [OFF_W-1:0] off;
        logic [4:0]       r;
        int               b;
        bit               in_bank;
        result_t          res;
        off     = s.offset & WORD_ALIGN;
        r       = off[4:0];
        b       = (int'(off) - int'(OFF_BANK_BASE)) / 32;
        in_bank = (off >= OFF_BANK_BASE) && (b < NUM_BANKS);
        res     = '0;
        case (s.func)
            FUNC_READ:
            begin
                pick_irq();
                if (off == OFF_SIR_IRQ)
                    res.rdata = irq_held ? DATA_W'(irq_num) : (SIR_SPURIOUS | DATA_W'(irq_num));
                else if (in_bank)
                begin
                    case (r)
                        REG_RAW:       res.rdata = line_st[b];
                        REG_MASK:      res.rdata = mask_st[b];
                        REG_FORCE_SET: res.rdata = force_st[b];
                        REG_PENDING:   res.rdata = bank_pending(b);
                        default:       res.rdata = '0;
                    endcase
                end
            end
            FUNC_WRITE:
            begin
                if (off == OFF_SYSCONFIG)
                begin
                    if (s.wdata[1])
                        clear_regs();
                end
                else if (off == OFF_CONTROL)
                begin
                    if (s.wdata[0])
                        irq_held = 1'b0;
                end
                else if (in_bank)
                begin
                    case (r)
                        REG_MASK:      mask_st[b]  = s.wdata;
                        REG_MASK_CLR:  mask_st[b]  = mask_st[b] & ~s.wdata;
                        REG_MASK_SET:  mask_st[b]  = mask_st[b] | s.wdata;
                        REG_FORCE_SET: force_st[b] = force_st[b] | s.wdata;
                        REG_FORCE_CLR: force_st[b] = force_st[b] & ~s.wdata;
                        default:       ;
                    endcase
                end
            end
            FUNC_LINES:
            begin
                if (s.bank < NUM_BANKS)
                    line_st[s.bank] = s.levels;
            end
            default: ;
        endcase
        pick_irq();
        res.irq      = irq_held;
        res.source   = irq_num;
        res.spurious = !irq_held;
        return res;
    endfunction

    // typed rows queue their own expectation but still advance the predictor
    task automatic send_beat(input step_t s, input int idle_pct, input bit typed,
                             input result_t want);
        result_t got;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start       <= 1'b1;
        func        <= s.func;
        byte_offset <= s.offset;
        write_data  <= s.wdata;
        line_bank   <= s.bank;
        line_levels <= s.levels;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        got = predict_beat(s);
        resp_q.push_back(typed ? want : got);
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        result_t exp_res;
        if (rst_n && done === 1'b1)
        begin
            if (resp_q.size() == 0)
            begin
                $error("result beat with nothing expected: read_data %h", read_data);
                fail_count++;
            end
            else
            begin
                exp_res = resp_q.pop_front();
                if (read_data !== exp_res.rdata)
                begin
                    $error("read_data: expected %h, got %h", exp_res.rdata, read_data);
                    fail_count++;
                end
                if (irq_request !== exp_res.irq)
                begin
                    $error("irq_request: expected %b, got %b", exp_res.irq, irq_request);
                    fail_count++;
                end
                if (active_source !== exp_res.source)
                begin
                    $error("active_source: expected %0d, got %0d", exp_res.source,
                           active_source);
                    fail_count++;
                end
                if (spurious !== exp_res.spurious)
                begin
                    $error("spurious: expected %b, got %b", exp_res.spurious, spurious);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        step_t s;
        int    pick;
        int    idle_pct;
        rst_n       <= 1'b0;
        start       <= 1'b0;
        func        <= FUNC_NOP;
        byte_offset <= '0;
        write_data  <= '0;
        line_bank   <= '0;
        line_levels <= '0;
        clear_regs();
        for (int b = 0; b < NUM_BANKS; b++)
            line_st[b] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_ROWS; i++)
            send_beat(DIRECTED[i].beat, 25, DIRECTED[i].typed, DIRECTED[i].want);

        for (int i = 0; i < RANDOM_BEATS; i++)
        begin
            if (i < RANDOM_BEATS / 3)
                idle_pct = 25;
            else if (i < 2 * RANDOM_BEATS / 3)
                idle_pct = 70;
            else
                idle_pct = 0;

            pick = $urandom_range(99);
            if (pick < 38)
                s.func = FUNC_READ;
            else if (pick < 75)
                s.func = FUNC_WRITE;
            else if (pick < 95)
                s.func = FUNC_LINES;
            else
                s.func = FUNC_NOP;

            pick = $urandom_range(99);
            if (pick < 8)
                s.offset = OFF_SIR_IRQ;
            else if (pick < 20)
                s.offset = OFF_CONTROL;
            else if (pick < 24)
                s.offset = OFF_SYSCONFIG;
            else if (pick < 92)
                s.offset = reg_at(($urandom_range(99) < 8) ? 3 : $urandom_range(2),
                                  BANK_REGS[$urandom_range(6)]);
            else
                s.offset = OFF_W'($urandom);
            // some unaligned accesses
            if ($urandom_range(9) == 0)
                s.offset[1:0] = 2'($urandom);

            case ($urandom_range(3))
                0:       s.wdata = $urandom;
                1:       s.wdata = 32'd1 << $urandom_range(31);
                2:       s.wdata = '1;
                default: s.wdata = $urandom & $urandom & $urandom;
            endcase

            s.bank = ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2));
            case ($urandom_range(3))
                0:       s.levels = $urandom;
                1:       s.levels = '0;
                2:       s.levels = '1;
                default: s.levels = $urandom & $urandom & $urandom;
            endcase

            send_beat(s, idle_pct, 1'b0, FROM_MODEL);
        end

        start <= 1'b0;
        while (resp_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/mic_pkg.sv
hw/rtl/mic_lowest_enc.sv
hw/rtl/mic_core.sv
hw/rtl/masked_interrupt_controller_top.sv
sim/tb_masked_interrupt_controller_top.sv
